// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

    // queue of decoded unit groups between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int MAX_UNITS = 3;
    localparam int GCNT_W    = $clog2(MAX_UNITS + 1);
    localparam int GIDX_W    = $clog2(MAX_UNITS);

    localparam logic [15:0] QMARK = 16'h003f;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_last;
    } byte_word_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_last;
    } unit_word_t;

    // up to three code units produced by one byte
    typedef struct packed {
        logic [GCNT_W-1:0]             cnt;
        logic [MAX_UNITS-1:0][15:0]    units;
        logic                          last;
    } unit_group_t;

endpackage

// ===== rtl/core/u8u16_front.sv =====
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  byte_word_t  byte_data,
    input  logic        q_full,
    output logic        push,
    output unit_group_t group
);

    function automatic logic [2:0] seq_len(input logic [7:0] x);
        if ((x & 8'he0) == 8'hc0)
        begin
            return 3'd2;
        end
        else if ((x & 8'hf0) == 8'he0)
        begin
            return 3'd3;
        end
        else if ((x & 8'hf8) == 8'hf0)
        begin
            return 3'd4;
        end
        return 3'd1;
    endfunction

    // ascii passes, any byte with bit 7 set is '?'
    function automatic logic [15:0] single_unit(input logic [7:0] x);
        return x[7] ? QMARK : {8'h00, x};
    endfunction

    logic [1:0]  hc_reg;
    logic [1:0]  hc_next;
    logic [7:0]  held_reg [3];

    logic        accept;
    logic        last;
    logic        hold;
    logic        complete;
    logic [7:0]  c;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [2:0]  n0;
    logic [20:0] cp;
    logic [20:0] v;
    unit_group_t g;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && !q_full;
    assign c          = byte_data.in_byte;
    assign last       = byte_data.byte_last;

    // sequence bytes so far, the incoming byte at position hc
    assign b0 = (hc_reg == 2'd0) ? c : held_reg[0];
    assign b1 = (hc_reg == 2'd1) ? c : held_reg[1];
    assign b2 = (hc_reg == 2'd2) ? c : held_reg[2];
    assign n0 = seq_len(b0);

    assign complete = (hc_reg != 2'd0) && (({1'b0, hc_reg} + 3'd1) == n0);

    always_comb
    begin
        case (n0)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default: cp = {b0[2:0], b1[5:0], b2[5:0], c[5:0]};
        endcase
    end

    assign v = cp - 21'h010000;

    always_comb
    begin
        g       = '0;
        hold    = 1'b0;
        hc_next = hc_reg;
        g.last  = last;
        if (complete)
        begin
            hc_next = 2'd0;
            if (cp[20:16] == 5'd0)
            begin
                g.cnt      = GCNT_W'(1);
                g.units[0] = cp[15:0];
            end
            else
            begin
                // values past 0x10ffff wrap to 16 bits
                g.cnt      = GCNT_W'(2);
                g.units[0] = 16'hd800 + {5'd0, v[20:10]};
                g.units[1] = 16'hdc00 + {6'd0, v[9:0]};
            end
        end
        else if (last)
        begin
            hc_next = 2'd0;
            if (hc_reg == 2'd0)
            begin
                g.cnt      = GCNT_W'(1);
                g.units[0] = single_unit(c);
            end
            else if (hc_reg == 2'd1)
            begin
                g.cnt      = GCNT_W'(2);
                g.units[0] = QMARK;
                g.units[1] = single_unit(c);
            end
            else
            begin
                // truncated lead gives '?', the second held byte and the final byte decode again
                g.units[0] = QMARK;
                if (seq_len(held_reg[1]) == 3'd2)
                begin
                    g.cnt      = GCNT_W'(2);
                    g.units[1] = {5'd0, held_reg[1][4:0], c[5:0]};
                end
                else
                begin
                    g.cnt      = GCNT_W'(3);
                    g.units[1] = single_unit(held_reg[1]);
                    g.units[2] = single_unit(c);
                end
            end
        end
        else if (hc_reg == 2'd0)
        begin
            if (n0 == 3'd1)
            begin
                g.cnt      = GCNT_W'(1);
                g.units[0] = single_unit(c);
            end
            else
            begin
                hold    = 1'b1;
                hc_next = 2'd1;
            end
        end
        else
        begin
            hold    = 1'b1;
            hc_next = hc_reg + 2'd1;
        end
    end

    assign push  = accept && (g.cnt != '0);
    assign group = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 2'd0;
        end
        else if (accept)
        begin
            hc_reg <= hc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold && (hc_reg != 2'd3))
        begin
            held_reg[hc_reg] <= c;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> hc_reg == 2'd0)
        else $error("held count not cleared after final byte");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |-> push)
        else $error("final byte produced no code unit");

endmodule

// ===== rtl/core/u8u16_queue.sv =====
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  unit_group_t push_group,
    input  logic        pop,
    output logic        full,
    output logic        empty,
    output unit_group_t head
);

    unit_group_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/u8u16_back.sv =====
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  unit_group_t head,
    output logic        pop,
    output logic        unit_valid,
    input  logic        unit_ready,
    output unit_word_t  unit_data
);

    logic              unit_valid_reg;
    logic              unit_valid_next;
    unit_word_t        unit_data_reg;
    unit_word_t        unit_data_next;
    logic [GIDX_W-1:0] idx_reg;
    logic [GIDX_W-1:0] idx_next;

    logic load;
    logic take;
    logic group_end;

    assign load      = !unit_valid_reg || unit_ready;
    assign take      = load && !empty;
    assign group_end = (GCNT_W'(idx_reg) + GCNT_W'(1)) == head.cnt;
    assign pop       = take && group_end;

    always_comb
    begin
        unit_valid_next = unit_valid_reg;
        unit_data_next  = unit_data_reg;
        idx_next        = idx_reg;
        if (load)
        begin
            unit_valid_next = !empty;
        end
        if (take)
        begin
            unit_data_next.code_unit = head.units[idx_reg];
            unit_data_next.unit_last = head.last && group_end;
            idx_next                 = group_end ? '0 : idx_reg + GIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            unit_valid_reg <= unit_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_data_reg <= unit_data_next;
    end

    assign unit_valid = unit_valid_reg;
    assign unit_data  = unit_data_reg;

    // a partly sent group stays at the head until its last unit leaves
    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != '0 |-> !empty)
        else $error("unit index set with no group queued");

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// utf-8 bytes in, utf-16 code units out, one byte accepted per cycle while the queue is not full
// a code unit goes through the queue and then the output register once the byte completing it is accepted
// throughput: one byte per cycle in, one code unit per cycle out while unit_ready is high; a surrogate
// pair or an end-of-string flush gives two or three code units, soaked up by a 4-deep queue
// reset: rst_n clears the held-byte count, the queue and the output valid; no clearing pass
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_word_t byte_data,
    output logic       unit_valid,
    input  logic       unit_ready,
    output unit_word_t unit_data
);

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    unit_group_t push_group;
    unit_group_t head;

    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .push       (push),
        .group      (push_group)
    );

    u8u16_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .head       (head),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 390;
    localparam int TAIL_CYCLES  = 8;

    typedef enum int {SEQ_ASCII, SEQ_MULTI, SEQ_STRAY, SEQ_CUT, SEQ_NOISE} seq_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    byte_word_t byte_data = '0;
    logic       unit_ready = 1'b0;
    logic       byte_ready;
    logic       unit_valid;
    unit_word_t unit_data;

    // predictor state
    logic [2:0][7:0] held_bytes;
    int              held_count = 0;
    unit_word_t      step_units[$];
    unit_word_t      exp_units[$];

    logic [7:0] str_bytes[$];

    int errors = 0;
    int units_checked = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int stall_max = 0;
    int stall_left = 0;
    int gap_max = 0;
    int burst_left = 0;
    int cycle_cnt = 0;

    utf8_to_utf16_transcoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d code units outstanding",
                     cycle_cnt, exp_units.size());
            $display("** utf8_to_utf16_transcoder: FAILED **");
            $finish;
        end
    end

    // receiver stalls of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            unit_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_max > 0 && $urandom_range(0, 3) == 0)
        begin
            unit_ready <= 1'b0;
            stall_left <= $urandom_range(0, stall_max - 1);
        end
        else
        begin
            unit_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : unit_checker
        unit_word_t want;
        if (rst_n && unit_valid && unit_ready)
        begin
            if (exp_units.size() == 0)
            begin
                $error("unexpected code unit %h (last %b)", unit_data.code_unit,
                       unit_data.unit_last);
                errors++;
            end
            else
            begin
                want = exp_units.pop_front();
                units_checked++;
                if (unit_data.code_unit !== want.code_unit)
                begin
                    $error("code_unit: expected %h, got %h", want.code_unit,
                           unit_data.code_unit);
                    errors++;
                end
                if (unit_data.unit_last !== want.unit_last)
                begin
                    $error("unit_last: expected %b, got %b", want.unit_last,
                           unit_data.unit_last);
                    errors++;
                end
            end
        end
    end

    function automatic int lead_len(logic [7:0] c);
        if ((c & 8'he0) == 8'hc0)
            return 2;
        if ((c & 8'hf0) == 8'he0)
            return 3;
        if ((c & 8'hf8) == 8'hf0)
            return 4;
        return 1;
    endfunction

    function automatic logic [31:0] decode_seq(logic [3:0][7:0] sb, int start, int n);
        logic [31:0] cp;
        int k;
        if (n == 2)
            cp = {27'd0, sb[start][4:0]};
        else if (n == 3)
            cp = {28'd0, sb[start][3:0]};
        else
            cp = {29'd0, sb[start][2:0]};
        for (k = 1; k < n; k++)
            cp = (cp << 6) | {26'd0, sb[start + k][5:0]};
        return cp;
    endfunction

    task automatic add_unit(input logic [31:0] u);
        unit_word_t w;
        w.code_unit = u[15:0];
        w.unit_last = 1'b0;
        if (step_units.size() < 4)
            step_units.insert(step_units.size(), w);
    endtask

    // values past 0x10ffff still split the same way and keep their low 16 bits
    task automatic add_codepoint(input logic [31:0] cp);
        logic [31:0] v;
        if (cp <= 32'h0000ffff)
        begin
            add_unit(cp);
        end
        else
        begin
            v = cp - 32'h00010000;
            add_unit(32'hd800 + (v >> 10));
            add_unit(32'hdc00 + (v & 32'h3ff));
        end
    endtask

    task automatic predict_units(input logic [7:0] c, input logic lst);
        logic [3:0][7:0] seq_b;
        unit_word_t w;
        int n;
        int i;
        int k;
        int len;
        int hc;
        step_units.delete();
        hc = held_count;
        seq_b = '0;
        for (k = 0; k < hc; k++)
            seq_b[k] = held_bytes[k];
        seq_b[hc] = c;
        if (lst)
        begin
            // end of string: decode held bytes plus this one from the lead again
            len = hc + 1;
            i = 0;
            while (i < len)
            begin
                n = lead_len(seq_b[i]);
                if (seq_b[i] < 8'h80)
                begin
                    add_codepoint({24'd0, seq_b[i]});
                    i++;
                end
                else if (n >= 2 && i + n <= len)
                begin
                    add_codepoint(decode_seq(seq_b, i, n));
                    i += n;
                end
                else
                begin
                    add_codepoint({16'd0, QMARK});
                    i++;
                end
            end
            held_count = 0;
        end
        else if (hc == 0)
        begin
            n = lead_len(c);
            if (c < 8'h80)
                add_codepoint({24'd0, c});
            else if (n == 1)
                add_codepoint({16'd0, QMARK});
            else
            begin
                held_bytes[0] = c;
                held_count = 1;
            end
        end
        else
        begin
            n = lead_len(held_bytes[0]);
            if (hc + 1 >= n)
            begin
                add_codepoint(decode_seq(seq_b, 0, n));
                held_count = 0;
            end
            else
            begin
                held_bytes[hc] = c;
                held_count = hc + 1;
            end
        end
        if (lst && step_units.size() > 0)
        begin
            w = step_units.pop_back();
            w.unit_last = 1'b1;
            step_units.insert(step_units.size(), w);
        end
        while (step_units.size() > 0)
            exp_units.insert(exp_units.size(), step_units.pop_front());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        byte_word_t w;
        w.in_byte = b;
        w.byte_last = lst;
        byte_data <= w;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        predict_units(b, lst);
        bytes_sent++;
        if (lst)
            strings_sent++;
    endtask

    task automatic send_paced(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_byte(b, lst);
    endtask

    task automatic send_string;
        int k;
        for (k = 0; k < str_bytes.size(); k++)
            send_paced(str_bytes[k], k == str_bytes.size() - 1);
    endtask

    task automatic add_str_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // sender holds off until every expected word is out
    task automatic drain_units;
        byte_valid <= 1'b0;
        @(posedge clk);
        while (exp_units.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] lead_byte(int n);
        if (n == 2)
            return 8'hc0 | 8'($urandom_range(0, 31));
        if (n == 3)
            return 8'he0 | 8'($urandom_range(0, 15));
        return 8'hf0 | 8'($urandom_range(0, 7));
    endfunction

    // continuation top bits are not checked, so some are fully random
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic test_single_bytes;
        gap_max = 0;
        stall_max = 0;
        send_paced(8'h00, 1'b0);
        send_paced(8'hff, 1'b0);
        send_paced(8'h80, 1'b0);
        send_paced(8'h7f, 1'b1);
    endtask

    task automatic test_full_sequences;
        gap_max = 2;
        stall_max = 3;
        // overlong two-byte form
        send_paced(8'hc0, 1'b0);
        send_paced(8'h80, 1'b0);
        send_paced(8'hef, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
        // encoded surrogate passes through
        send_paced(8'hed, 1'b0);
        send_paced(8'ha0, 1'b0);
        send_paced(8'h80, 1'b0);
        send_paced(8'hf4, 1'b0);
        send_paced(8'h8f, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
        // above 0x10ffff, completed by the final byte
        send_paced(8'hf7, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b1);
    endtask

    task automatic test_cut_strings;
        gap_max = 1;
        stall_max = 8;
        send_paced(8'he2, 1'b0);
        send_paced(8'h82, 1'b1);
        // each held byte gets a question mark on the flush
        send_paced(8'hf0, 1'b0);
        send_paced(8'he0, 1'b0);
        send_paced(8'hc3, 1'b1);
        drain_units();
    endtask

    task automatic test_random_strings;
        int stop_at;
        int nseq;
        int k;
        int j;
        int n;
        int r;
        int n_str;
        seq_kind_t kind;
        stop_at = bytes_sent + RANDOM_BYTES;
        n_str = 0;
        while (bytes_sent < stop_at)
        begin
            if (n_str % 8 == 0)
            begin
                // pacing phase, sometimes with no idling at all
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            str_bytes.delete();
            nseq = $urandom_range(1, 10);
            for (k = 0; k < nseq; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    kind = SEQ_ASCII;
                else if (r < 7)
                    kind = SEQ_MULTI;
                else if (r == 7)
                    kind = SEQ_STRAY;
                else if (r == 8)
                    kind = SEQ_CUT;
                else
                    kind = SEQ_NOISE;
                case (kind)
                    SEQ_ASCII:
                        add_str_byte(8'($urandom_range(0, 127)));
                    SEQ_MULTI:
                    begin
                        n = $urandom_range(2, 4);
                        add_str_byte(lead_byte(n));
                        for (j = 1; j < n; j++)
                            add_str_byte(cont_byte());
                    end
                    SEQ_STRAY:
                        if ($urandom_range(0, 1) == 0)
                            add_str_byte(8'($urandom_range(8'h80, 8'hbf)));
                        else
                            add_str_byte(8'($urandom_range(8'hf8, 8'hff)));
                    SEQ_CUT:
                    begin
                        n = $urandom_range(2, 4);
                        add_str_byte(lead_byte(n));
                        for (j = $urandom_range(0, n - 2); j > 0; j--)
                            add_str_byte(cont_byte());
                    end
                    default:
                        add_str_byte(8'($urandom_range(0, 255)));
                endcase
            end
            send_string();
            n_str++;
            if (n_str == 1 || $urandom_range(0, 15) == 0)
                drain_units();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_bytes();
        test_full_sequences();
        test_cut_strings();
        test_random_strings();
        byte_valid <= 1'b0;
        while (exp_units.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d bytes in %0d strings, checked %0d code units",
                 bytes_sent, strings_sent, units_checked);
        $display("ascii, stray leads, 2/3/4-byte forms, surrogate pairs, cut strings, stalls");
        if (errors == 0)
            $display("** utf8_to_utf16_transcoder: PASSED **");
        else
            $display("** utf8_to_utf16_transcoder: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_front.sv
rtl/core/u8u16_queue.sv
rtl/core/u8u16_back.sv
rtl/core/utf8_to_utf16_transcoder.sv
sim/tb.sv
